### rtl/sal_pkg.sv
// Shared types and codes for the shifting array list.
`default_nettype none
package sal_pkg;

    localparam int OP_W     = 4;
    localparam int POS_W    = 4;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;
    localparam int CAP_W    = 5;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT   = 4'd0;
    localparam logic [OP_W-1:0] OP_POP_FRONT    = 4'd1;
    localparam logic [OP_W-1:0] OP_APPEND       = 4'd2;
    localparam logic [OP_W-1:0] OP_REMOVE_BACK  = 4'd3;
    localparam logic [OP_W-1:0] OP_PEEK_FIRST   = 4'd4;
    localparam logic [OP_W-1:0] OP_PEEK_LAST    = 4'd5;
    localparam logic [OP_W-1:0] OP_READ_AT      = 4'd6;
    localparam logic [OP_W-1:0] OP_INSERT_BEFORE = 4'd7;
    localparam logic [OP_W-1:0] OP_INSERT_AFTER = 4'd8;
    localparam logic [OP_W-1:0] OP_CLEAR        = 4'd9;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BOUNDS = 2'd3;

    typedef struct packed {
        logic [FILL_W-1:0]   fill;
        logic [WORD_W-1:0]   word;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage
`default_nettype wire

### rtl/sal_mem.sv
// Entry store: one write port, one read port with registered read data.
`default_nettype none
module sal_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### rtl/sal_ctrl.sv
// Request sequencer: decode, bounds and fill checks, entry shifting through the store.
`default_nettype none
module sal_ctrl #(
    parameter int DEPTH      = 16,
    parameter int WORD_WIDTH = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [sal_pkg::CAP_W-1:0]     i_cap,
    input  wire logic                          i_req_valid,
    output logic                               o_req_ready,
    input  wire logic [sal_pkg::OP_W-1:0]      i_op,
    input  wire logic [sal_pkg::POS_W-1:0]     i_pos,
    input  wire logic [sal_pkg::WORD_W-1:0]    i_word,
    input  wire logic                          i_del,
    input  wire logic                          i_res_free,
    output logic                               o_res_valid,
    output sal_pkg::t_result                   o_res,
    output logic                               o_mem_we,
    output logic [$clog2(DEPTH)-1:0]           o_mem_waddr,
    output logic [WORD_WIDTH-1:0]              o_mem_wdata,
    output logic                               o_mem_re,
    output logic [$clog2(DEPTH)-1:0]           o_mem_raddr,
    input  wire logic [WORD_WIDTH-1:0]         i_mem_rdata
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > sal_pkg::CAP_W) ? CW : sal_pkg::CAP_W;

    typedef enum logic [2:0] {
        S_IDLE, S_RD_WORD, S_CAP_WORD, S_SH_RD, S_SH_WR, S_WR_NEW, S_DONE
    } t_state;

    typedef enum logic [1:0] {
        C_HOLD, C_INC, C_DEC, C_CLEAR
    } t_cnt_op;

    t_state                          r_state;
    t_cnt_op                         r_cnt_op;
    logic [CW-1:0]                   r_count;
    logic [CW-1:0]                   r_ptr;
    logic [CW-1:0]                   r_tgt;
    logic                            r_del;
    logic [WORD_WIDTH-1:0]           r_word;
    logic [WORD_WIDTH-1:0]           r_wnew;
    logic [sal_pkg::STATUS_W-1:0]    r_status;

    logic [CMPW-1:0] count_ext;
    logic [CMPW-1:0] cap_ext;
    logic [CMPW-1:0] pos_ext;
    logic            full;
    logic            empty;
    logic            out_of_bounds;
    logic [CW-1:0]   count_m1;
    logic [CW-1:0]   pos_c;
    logic [CW-1:0]   n_count;
    logic            accept;

    always_comb begin
        count_ext     = CMPW'(r_count);
        cap_ext       = CMPW'(i_cap);
        pos_ext       = CMPW'(i_pos);
        empty         = (r_count == '0);
        full          = (count_ext >= CMPW'(DEPTH)) ||
                        ((i_cap != '0) ? (count_ext >= cap_ext) : !empty);
        out_of_bounds = (pos_ext >= count_ext);
        count_m1      = r_count - CW'(1);
        pos_c         = CW'(i_pos);
        accept        = i_req_valid && (r_state == S_IDLE);
    end

    always_comb begin
        case (r_cnt_op)
            C_INC:   n_count = r_count + CW'(1);
            C_DEC:   n_count = r_count - CW'(1);
            C_CLEAR: n_count = '0;
            default: n_count = r_count;
        endcase
    end

    always_comb begin
        o_mem_re    = 1'b0;
        o_mem_raddr = r_ptr[AW-1:0];
        o_mem_we    = 1'b0;
        o_mem_waddr = r_ptr[AW-1:0];
        o_mem_wdata = i_mem_rdata;
        case (r_state)
            S_RD_WORD: begin
                o_mem_re = 1'b1;
            end
            S_SH_RD: begin
                o_mem_re = 1'b1;
                if (r_del) begin
                    o_mem_raddr = AW'(r_ptr + CW'(1));
                end else begin
                    o_mem_raddr = AW'(r_ptr - CW'(1));
                end
            end
            S_SH_WR: begin
                o_mem_we = 1'b1;
            end
            S_WR_NEW: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_tgt[AW-1:0];
                o_mem_wdata = r_wnew;
            end
            default: begin
                o_mem_re = 1'b0;
            end
        endcase
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE) && i_res_free;
    assign o_res.status = r_status;
    assign o_res.word   = sal_pkg::WORD_W'(r_word);
    assign o_res.fill   = sal_pkg::FILL_W'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_cnt_op <= C_HOLD;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_status <= sal_pkg::ST_OK;
                        r_word   <= '0;
                        r_wnew   <= WORD_WIDTH'(i_word);
                        r_del    <= 1'b0;
                        r_cnt_op <= C_HOLD;
                        r_state  <= S_DONE;
                        case (i_op)
                            sal_pkg::OP_PUSH_FRONT, sal_pkg::OP_APPEND: begin
                                if (full) begin
                                    r_status <= sal_pkg::ST_FULL;
                                end else begin
                                    r_ptr    <= r_count;
                                    r_tgt    <= (i_op == sal_pkg::OP_APPEND) ? r_count : '0;
                                    r_cnt_op <= C_INC;
                                    r_state  <= ((i_op == sal_pkg::OP_APPEND) || empty)
                                                ? S_WR_NEW : S_SH_RD;
                                end
                            end
                            sal_pkg::OP_POP_FRONT, sal_pkg::OP_REMOVE_BACK: begin
                                if (empty) begin
                                    r_status <= sal_pkg::ST_EMPTY;
                                end else begin
                                    r_ptr    <= (i_op == sal_pkg::OP_REMOVE_BACK)
                                                ? count_m1 : '0;
                                    r_del    <= 1'b1;
                                    r_cnt_op <= C_DEC;
                                    r_state  <= S_RD_WORD;
                                end
                            end
                            sal_pkg::OP_PEEK_FIRST, sal_pkg::OP_PEEK_LAST: begin
                                if (empty) begin
                                    r_status <= sal_pkg::ST_EMPTY;
                                end else begin
                                    r_ptr   <= (i_op == sal_pkg::OP_PEEK_LAST) ? count_m1 : '0;
                                    r_state <= S_RD_WORD;
                                end
                            end
                            sal_pkg::OP_READ_AT: begin
                                if (out_of_bounds) begin
                                    r_status <= sal_pkg::ST_BOUNDS;
                                end else begin
                                    r_ptr    <= pos_c;
                                    r_del    <= i_del;
                                    r_cnt_op <= i_del ? C_DEC : C_HOLD;
                                    r_state  <= S_RD_WORD;
                                end
                            end
                            sal_pkg::OP_INSERT_BEFORE, sal_pkg::OP_INSERT_AFTER: begin
                                if (out_of_bounds) begin
                                    r_status <= sal_pkg::ST_BOUNDS;
                                end else if (full) begin
                                    r_status <= sal_pkg::ST_FULL;
                                end else begin
                                    r_ptr    <= r_count;
                                    r_cnt_op <= C_INC;
                                    if (i_op == sal_pkg::OP_INSERT_AFTER) begin
                                        r_tgt   <= pos_c + CW'(1);
                                        r_state <= ((pos_c + CW'(1)) == r_count)
                                                   ? S_WR_NEW : S_SH_RD;
                                    end else begin
                                        r_tgt   <= pos_c;
                                        r_state <= S_SH_RD;
                                    end
                                end
                            end
                            sal_pkg::OP_CLEAR: begin
                                r_cnt_op <= C_CLEAR;
                            end
                            default: begin
                                r_cnt_op <= C_HOLD;
                            end
                        endcase
                    end
                end
                S_RD_WORD: begin
                    r_state <= S_CAP_WORD;
                end
                S_CAP_WORD: begin
                    r_word  <= i_mem_rdata;
                    r_state <= (r_del && ((r_ptr + CW'(1)) < r_count)) ? S_SH_RD : S_DONE;
                end
                S_SH_RD: begin
                    r_state <= S_SH_WR;
                end
                S_SH_WR: begin
                    if (r_del) begin
                        r_ptr   <= r_ptr + CW'(1);
                        r_state <= ((r_ptr + CW'(2)) < r_count) ? S_SH_RD : S_DONE;
                    end else begin
                        r_ptr   <= r_ptr - CW'(1);
                        r_state <= ((r_ptr - CW'(1)) > r_tgt) ? S_SH_RD : S_WR_NEW;
                    end
                end
                S_WR_NEW: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_res_free) begin
                        r_count <= n_count;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### rtl/shifting_array_list_core.sv
// Errors, clear and ignored codes go straight to the result; peeks and reads fetch one word
// from the entry store; deletes and pops also shift the entries after the position down by
// one, and pushes, appends and inserts shift the entries from the target on up by one before
// writing the new word; each moved entry is read from and written back to the entry store.
// One request is in flight at a time. Synchronous active-low reset empties the list, sets
// the capacity to 16 and drops any pending result; stored words stay.
`default_nettype none
module shifting_array_list_core #(
    parameter int DEPTH      = 16,
    parameter int WORD_WIDTH = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [sal_pkg::CAP_W-1:0]           i_cfg_data,  // capacity_in_use
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // operation[3:0], position[7:4], word_in[39:8]
    input  wire logic [sal_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    input  wire logic                                i_s_tuser,   // delete_at
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // status[1:0], word_out[33:2], fill_count[38:34], zero[39]
    output logic [sal_pkg::OUT_TDATA_W-1:0]          o_m_tdata
);

    localparam int AW = $clog2(DEPTH);

    logic [sal_pkg::CAP_W-1:0] r_cap;
    logic                      r_m_valid;
    sal_pkg::t_result          r_m_res;

    sal_pkg::t_result          res;
    logic                      res_valid;
    logic                      res_free;

    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic [WORD_WIDTH-1:0]     mem_wdata;
    logic                      mem_re;
    logic [AW-1:0]             mem_raddr;
    logic [WORD_WIDTH-1:0]     mem_rdata;

    assign o_cfg_ready = 1'b1;
    assign res_free    = !r_m_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= sal_pkg::CAP_RESET;
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_valid) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_m_res <= res;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = sal_pkg::OUT_TDATA_W'(r_m_res);

    sal_ctrl #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cap       (r_cap),
        .i_req_valid (i_s_tvalid),
        .o_req_ready (o_s_tready),
        .i_op        (i_s_tdata[3:0]),
        .i_pos       (i_s_tdata[7:4]),
        .i_word      (i_s_tdata[39:8]),
        .i_del       (i_s_tuser),
        .i_res_free  (res_free),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    sal_mem #(
        .DEPTH (DEPTH),
        .WIDTH (WORD_WIDTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule
`default_nettype wire

### rtl/sal_checker.sv
// Port-level checks on the result channel, bound to the list core.
`default_nettype none
module sal_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_m_tvalid,
    input wire logic                              i_m_tready,
    input wire logic [sal_pkg::OUT_TDATA_W-1:0]   i_m_tdata
);

    logic [sal_pkg::STATUS_W-1:0] status;
    logic [sal_pkg::WORD_W-1:0]   word;
    logic [sal_pkg::FILL_W-1:0]   fill;

    assign status = i_m_tdata[1:0];
    assign word   = i_m_tdata[33:2];
    assign fill   = i_m_tdata[38:34];

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result beat shown right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("stalled result beat changed");

    a_error_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (status != sal_pkg::ST_OK) |-> (word == '0))
        else $error("failed request returned a word");

    a_empty_no_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (status == sal_pkg::ST_EMPTY) |-> (fill == '0))
        else $error("empty status with entries held");

endmodule

bind shifting_array_list_core sal_checker u_sal_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);
`default_nettype wire
